// ===== hw/rtl/poisson_stencil_row_generator_top_assert.svh =====
// Assertion macros used by the checker file of the stencil row generator.
`ifndef POISSON_STENCIL_ROW_GENERATOR_TOP_ASSERT_SVH
`define POISSON_STENCIL_ROW_GENERATOR_TOP_ASSERT_SVH

// Consequent checked in the cycle after the antecedent matches.
`define PSRG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the cycle where the antecedent matches.
`define PSRG_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/psrg_pkg.sv =====
// Shared constants, types and helpers of the stencil row generator.
`default_nettype none

package psrg_pkg;

  localparam int unsigned ROW_W        = 20;
  localparam int unsigned DIM_W        = 11;
  localparam int unsigned COEF_W       = 32;
  localparam int unsigned VAL_W        = 36;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned MAX_GRID_DIM = 1024;
  localparam int unsigned NUM_TAPS     = 5;
  localparam int unsigned DIV_STEPS    = 4;
  localparam int unsigned DIV_STAGES   = ROW_W / DIV_STEPS;
  localparam int unsigned AREA_W       = 2 * DIM_W;
  localparam int unsigned SUM_W        = COEF_W + 2;

  localparam logic [VAL_W-1:0] Q_ONE     = VAL_W'(65536);
  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_GRID_DIM);
  localparam logic [COEF_W-1:0] COEF_RST = COEF_W'(65536);

  // Tap positions in ascending column order.
  localparam int unsigned TAP_DOWN  = 0;
  localparam int unsigned TAP_LEFT  = 1;
  localparam int unsigned TAP_DIAG  = 2;
  localparam int unsigned TAP_RIGHT = 3;
  localparam int unsigned TAP_UP    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_COEFF_X     = 2'd2,
    CFG_COEFF_Y     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             in_range;
    logic [DIM_W-1:0] rem;
    logic [ROW_W-1:0] num;
  } div_t;

  typedef struct packed {
    logic [NUM_TAPS-1:0][ROW_W-1:0] col;
    logic [NUM_TAPS-1:0][VAL_W-1:0] val;
    logic [NUM_TAPS-1:0]            mask;
  } entry_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    if (v > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/psrg_div_stage.sv =====
// One registered stage of the row-by-width restoring divider.
`default_nettype none

module psrg_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  psrg_pkg::div_t in_data_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output psrg_pkg::div_t out_data_o,
  input  logic          out_ready_i
);
  import psrg_pkg::*;

  div_t             step_d;
  div_t             data_q;
  logic             valid_q;
  logic [DIM_W:0]   trial;
  logic             qbit;

  // Retire DIV_STEPS quotient bits, MSB first.
  always_comb begin
    step_d = in_data_i;
    trial  = '0;
    qbit   = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {step_d.rem, step_d.num[ROW_W-1]};
      if (trial >= {1'b0, step_d.w}) begin
        step_d.rem = DIM_W'(trial - {1'b0, step_d.w});
        qbit       = 1'b1;
      end else begin
        step_d.rem = trial[DIM_W-1:0];
        qbit       = 1'b0;
      end
      step_d.num = {step_d.num[ROW_W-2:0], qbit};
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= step_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/psrg_decode.sv =====
// Neighbor decode and entry build: two registered stages after the divider.
`default_nettype none

module psrg_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [psrg_pkg::COEF_W-1:0] coeff_x_i,
  input  logic [psrg_pkg::COEF_W-1:0] coeff_y_i,
  input  logic                        in_valid_i,
  input  psrg_pkg::div_t              in_data_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  output psrg_pkg::entry_t            out_data_o,
  input  logic                        out_ready_i
);
  import psrg_pkg::*;

  // Stage C: neighbor flags and coefficient sums.
  logic             c_valid_q;
  logic [ROW_W-1:0] c_row_q;
  logic [DIM_W-1:0] c_w_q;
  logic             c_in_range_q;
  logic             c_row_zero_q;
  logic             c_down_q, c_left_q, c_right_q, c_up_q;
  logic [SUM_W-1:0] c_xsum_q, c_ysum_q;
  logic             c_ready;

  // Stage D: finished entry set.
  logic             d_valid_q;
  entry_t           d_data_q;
  logic             d_ready;

  logic             down_d, left_d, right_d, up_d;
  logic [SUM_W-1:0] xsum_d, ysum_d;
  logic [ROW_W-1:0] h_m1;
  logic [DIM_W-1:0] w_m1;
  entry_t           entry_d;
  logic [VAL_W-1:0] pin;

  assign h_m1    = ROW_W'(in_data_i.h) - ROW_W'(1);
  assign w_m1    = in_data_i.w - DIM_W'(1);
  assign down_d  = in_data_i.num != '0;
  assign up_d    = in_data_i.num < h_m1;
  assign left_d  = in_data_i.rem != '0;
  assign right_d = in_data_i.rem < w_m1;

  always_comb begin
    case ({left_d, right_d})
      2'b11:        xsum_d = {1'b0, coeff_x_i, 1'b0};
      2'b10, 2'b01: xsum_d = {2'b00, coeff_x_i};
      default:      xsum_d = '0;
    endcase
    case ({down_d, up_d})
      2'b11:        ysum_d = {1'b0, coeff_y_i, 1'b0};
      2'b10, 2'b01: ysum_d = {2'b00, coeff_y_i};
      default:      ysum_d = '0;
    endcase
  end

  assign c_ready    = !c_valid_q || d_ready;
  assign d_ready    = !d_valid_q || out_ready_i;
  assign in_ready_o = c_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_row_q      <= in_data_i.row;
      c_w_q        <= in_data_i.w;
      c_in_range_q <= in_data_i.in_range;
      c_row_zero_q <= in_data_i.row == '0;
      c_down_q     <= down_d;
      c_left_q     <= left_d;
      c_right_q    <= right_d;
      c_up_q       <= up_d;
      c_xsum_q     <= xsum_d;
      c_ysum_q     <= ysum_d;
    end
  end

  assign pin = c_row_zero_q ? Q_ONE : '0;

  always_comb begin
    entry_d.col[TAP_DOWN]  = c_row_q - ROW_W'(c_w_q);
    entry_d.col[TAP_LEFT]  = c_row_q - ROW_W'(1);
    entry_d.col[TAP_DIAG]  = c_row_q;
    entry_d.col[TAP_RIGHT] = c_row_q + ROW_W'(1);
    entry_d.col[TAP_UP]    = c_row_q + ROW_W'(c_w_q);
    entry_d.val[TAP_DOWN]  = VAL_W'(coeff_y_i);
    entry_d.val[TAP_LEFT]  = VAL_W'(coeff_x_i);
    entry_d.val[TAP_DIAG]  = pin - VAL_W'(c_xsum_q) - VAL_W'(c_ysum_q);
    entry_d.val[TAP_RIGHT] = VAL_W'(coeff_x_i);
    entry_d.val[TAP_UP]    = VAL_W'(coeff_y_i);
    // Drop every entry of a row outside the grid.
    entry_d.mask = c_in_range_q ? {c_up_q, c_right_q, 1'b1, c_left_q, c_down_q} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_ready) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready && c_valid_q) begin
      d_data_q <= entry_d;
    end
  end

  assign out_valid_o = d_valid_q;
  assign out_data_o  = d_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/psrg_emit.sv =====
// Entry sequencer: sends the pending entries of one row, one per cycle.
`default_nettype none

module psrg_emit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  psrg_pkg::entry_t                  in_data_i,
  output logic                              in_ready_o,
  output logic                              valid_o,
  output logic [psrg_pkg::ROW_W-1:0]        column_index_o,
  output logic signed [psrg_pkg::VAL_W-1:0] entry_value_o,
  output logic                              last_entry_o
);
  import psrg_pkg::*;

  logic [NUM_TAPS-1:0] mask_q, mask_d;
  entry_t              data_q;
  logic [NUM_TAPS-1:0] pick;
  logic [ROW_W-1:0]    col_sel;
  logic [VAL_W-1:0]    val_sel;

  assign pick   = mask_q & (~mask_q + NUM_TAPS'(1));
  assign mask_d = mask_q & ~pick;

  always_comb begin
    col_sel = '0;
    val_sel = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (pick[k]) begin
        col_sel = col_sel | data_q.col[k];
        val_sel = val_sel | data_q.val[k];
      end
    end
  end

  // Take the next row once at most one entry is left.
  assign in_ready_o = (mask_q & (mask_q - NUM_TAPS'(1))) == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (in_ready_o && in_valid_i) begin
      mask_q <= in_data_i.mask;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o        = mask_q != '0;
  assign column_index_o = col_sel;
  assign entry_value_o  = val_sel;
  assign last_entry_o   = valid_o && (mask_d == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/poisson_stencil_row_generator_top.sv =====
// Top level of the five-point Laplacian matrix row generator.
//
// Usage: program grid_width, grid_height, coeff_x and coeff_y through the
// cfg write channel (index 0..3, cfg_ready_o is always high) while the block
// is idle. Issue a row request by raising start with row_index_i; it is taken
// at a clock edge where start is high and busy is low. The row's nonzero
// entries then appear on valid_o / column_index_o / entry_value_o in
// ascending column order, one per cycle, last_entry_o marking the final one.
// A taken request passes the input register, five divider stages, decode,
// build and the sequencer load before its first entry is on the ports. A
// row occupies the output sequencer while its entries (3 to 5) go out; a
// row outside the grid yields no entry. Requests may arrive every cycle;
// busy rises when the sequencer backs up the pipeline. Reset clears all
// pipeline valid bits and loads the register defaults. Results cannot be
// held off: each entry is shown for one cycle.
`default_nettype none

module poisson_stencil_row_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [psrg_pkg::ROW_W-1:0]          row_index_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [psrg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [psrg_pkg::COEF_W-1:0]         cfg_data_i,
  output logic                                valid_o,
  output logic [psrg_pkg::ROW_W-1:0]          column_index_o,
  output logic signed [psrg_pkg::VAL_W-1:0]   entry_value_o,
  output logic                                last_entry_o
);
  import psrg_pkg::*;

  logic [DIM_W-1:0]  grid_width_q, grid_height_q;
  logic [COEF_W-1:0] coeff_x_q, coeff_y_q;

  logic              a_valid_q;
  logic [ROW_W-1:0]  a_row_q;
  logic [DIM_W-1:0]  a_w_q, a_h_q;
  logic              a_ready;
  logic              accept;
  logic [AREA_W-1:0] area;

  logic   div_valid [DIV_STAGES+1];
  div_t   div_data  [DIV_STAGES+1];
  logic   div_ready [DIV_STAGES+1];

  logic   ent_valid;
  entry_t ent_data;
  logic   ent_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DIM_MIN;
      grid_height_q <= DIM_MIN;
      coeff_x_q     <= COEF_RST;
      coeff_y_q     <= COEF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_COEFF_X:     coeff_x_q     <= cfg_data_i;
        CFG_COEFF_Y:     coeff_y_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register with clamped grid size.
  assign a_ready = !a_valid_q || div_ready[0];
  assign busy    = !a_ready;
  assign accept  = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_row_q <= row_index_i;
      a_w_q   <= clamp_dim(grid_width_q);
      a_h_q   <= clamp_dim(grid_height_q);
    end
  end

  assign area = AREA_W'(a_w_q) * AREA_W'(a_h_q);

  // Fields in order: row, w, h, in_range, rem, num.
  assign div_valid[0] = a_valid_q;
  assign div_data[0]  = {a_row_q, a_w_q, a_h_q, AREA_W'(a_row_q) < area,
                         DIM_W'(0), a_row_q};

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    psrg_div_stage u_div_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[s]),
      .in_data_i   (div_data[s]),
      .in_ready_o  (div_ready[s]),
      .out_valid_o (div_valid[s+1]),
      .out_data_o  (div_data[s+1]),
      .out_ready_i (div_ready[s+1])
    );
  end

  psrg_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coeff_x_i   (coeff_x_q),
    .coeff_y_i   (coeff_y_q),
    .in_valid_i  (div_valid[DIV_STAGES]),
    .in_data_i   (div_data[DIV_STAGES]),
    .in_ready_o  (div_ready[DIV_STAGES]),
    .out_valid_o (ent_valid),
    .out_data_o  (ent_data),
    .out_ready_i (ent_ready)
  );

  psrg_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (ent_valid),
    .in_data_i      (ent_data),
    .in_ready_o     (ent_ready),
    .valid_o        (valid_o),
    .column_index_o (column_index_o),
    .entry_value_o  (entry_value_o),
    .last_entry_o   (last_entry_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/psrg_checker.sv =====
// Port-level checker for the stencil row generator, bound to the top level.
`default_nettype none

`include "poisson_stencil_row_generator_top_assert.svh"

module psrg_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       valid_o,
  input logic                       last_entry_o,
  input logic [psrg_pkg::ROW_W-1:0] column_index_o
);

  // Entries of one row come out in consecutive cycles.
  `PSRG_ASSERT_NEXT(a_row_contiguous, clk_i, rst_ni, valid_o && !last_entry_o, valid_o, "row entries not contiguous")

  // Columns rise within a row.
  `PSRG_ASSERT_NEXT(a_col_ascending, clk_i, rst_ni, valid_o && !last_entry_o, column_index_o > $past(column_index_o), "columns not ascending")

  // A row never has more than five entries.
  `PSRG_ASSERT_NEXT(a_max_five, clk_i, rst_ni, (valid_o && !last_entry_o) ##1 (valid_o && !last_entry_o) ##1 (valid_o && !last_entry_o) ##1 (valid_o && !last_entry_o), valid_o && last_entry_o, "row longer than five entries")

  // The last flag only marks a shown entry.
  `PSRG_ASSERT_SAME(a_last_valid, clk_i, rst_ni, last_entry_o, valid_o, "last flag without entry")

endmodule

bind poisson_stencil_row_generator_top psrg_checker u_psrg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_o        (valid_o),
  .last_entry_o   (last_entry_o),
  .column_index_o (column_index_o)
);

`default_nettype wire

// ===== tb/poisson_stencil_row_generator_top_tb.sv =====
// Self-checking testbench for the five-point Laplacian matrix row generator.
`default_nettype none

module poisson_stencil_row_generator_top_tb;
  import psrg_pkg::*;

  typedef struct {
    logic [ROW_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
    logic                    last;
  } stencil_entry_t;

  class stencil_scoreboard;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [COEF_W-1:0] coeff_x_reg;
    logic [COEF_W-1:0] coeff_y_reg;
    stencil_entry_t    pending_entries[$];
    int unsigned       mismatches;
    int unsigned       rows_taken;
    int unsigned       rows_outside;
    int unsigned       entries_checked;

    function new();
      width_reg   = DIM_W'(2);
      height_reg  = DIM_W'(2);
      coeff_x_reg = COEF_RST;
      coeff_y_reg = COEF_RST;
    endfunction

    function int unsigned dim_used(logic [DIM_W-1:0] v);
      if (v < 2) return 2;
      if (v > MAX_GRID_DIM) return MAX_GRID_DIM;
      return 32'(v);
    endfunction

    function int unsigned used_width();
      return dim_used(width_reg);
    endfunction

    function int unsigned used_height();
      return dim_used(height_reg);
    endfunction

    function int unsigned outstanding();
      return pending_entries.size();
    endfunction

    function void set_reg(cfg_reg_e idx, logic [COEF_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH:  width_reg = data[DIM_W-1:0];
        CFG_GRID_HEIGHT: height_reg = data[DIM_W-1:0];
        CFG_COEFF_X:     coeff_x_reg = data;
        CFG_COEFF_Y:     coeff_y_reg = data;
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void push_entry(int unsigned col, longint val);
      stencil_entry_t e;
      e.col  = col[ROW_W-1:0];
      e.val  = val[VAL_W-1:0];
      e.last = 1'b0;
      pending_entries.push_back(e);
    endfunction

    // Expand one accepted row request into its stencil entries.
    function void note_row(logic [ROW_W-1:0] row);
      int unsigned w, h, r, gi, gj;
      longint cx, cy, diag;
      bit has_down, has_left, has_right, has_up;
      w = used_width();
      h = used_height();
      r = 32'(row);
      rows_taken++;
      if (r >= w * h) begin
        rows_outside++;
        return;
      end
      gi = r % w;
      gj = r / w;
      has_down  = gj > 0;
      has_up    = gj < h - 1;
      has_left  = gi > 0;
      has_right = gi < w - 1;
      cx = longint'(coeff_x_reg);
      cy = longint'(coeff_y_reg);
      diag = 0;
      if (has_left) diag -= cx;
      if (has_right) diag -= cx;
      if (has_down) diag -= cy;
      if (has_up) diag -= cy;
      // pin the solution at the first cell
      if (r == 0) diag += longint'(Q_ONE);
      if (has_down) push_entry(r - w, cy);
      if (has_left) push_entry(r - 1, cx);
      push_entry(r, diag);
      if (has_right) push_entry(r + 1, cx);
      if (has_up) push_entry(r + w, cy);
      pending_entries[pending_entries.size() - 1].last = 1'b1;
    endfunction

    task check_entry(logic [ROW_W-1:0] col, logic signed [VAL_W-1:0] val, logic last);
      stencil_entry_t e;
      entries_checked++;
      if (pending_entries.size() == 0) begin
        report_mismatch($sformatf("unexpected entry col %0d val %0d", col, val));
        return;
      end
      e = pending_entries.pop_front();
      if (col !== e.col)
        report_mismatch($sformatf("column %0d, want %0d", col, e.col));
      if (val !== e.val)
        report_mismatch($sformatf("value %0d at col %0d, want %0d", val, e.col, e.val));
      if (last !== e.last)
        report_mismatch($sformatf("last flag %b at col %0d, want %b", last, e.col, e.last));
    endtask

    task flag_leftovers();
      stencil_entry_t e;
      while (pending_entries.size() > 0) begin
        e = pending_entries.pop_front();
        report_mismatch($sformatf("missing entry col %0d val %0d", e.col, e.val));
      end
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ROW_W-1:0]        row_index_i = '0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = CFG_GRID_WIDTH;
  logic [COEF_W-1:0]       cfg_data_i = '0;
  logic                    valid_o;
  logic [ROW_W-1:0]        column_index_o;
  logic signed [VAL_W-1:0] entry_value_o;
  logic                    last_entry_o;

  stencil_scoreboard sb = new();
  int unsigned       grids_used;

  poisson_stencil_row_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .row_index_i    (row_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .valid_o        (valid_o),
    .column_index_o (column_index_o),
    .entry_value_o  (entry_value_o),
    .last_entry_o   (last_entry_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_entry(column_index_o, entry_value_o, last_entry_o);
  end

  task automatic send_row(logic [ROW_W-1:0] row);
    @(negedge clk_i);
    start = 1'b1;
    row_index_i = row;
    do @(posedge clk_i); while (busy);
    sb.note_row(row);
  endtask

  // Idle the request side for a geometric number of cycles.
  task automatic hold_off(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start = 1'b0;
      row_index_i = ROW_W'($urandom);
    end
  endtask

  // Drain all expected entries, then let rows that yield nothing clear the pipe.
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    @(negedge clk_i);
    start = 1'b0;
    while (sb.outstanding() > 0 && n < 5000) begin
      @(negedge clk_i);
      n++;
    end
    if (sb.outstanding() > 0) sb.flag_leftovers();
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [COEF_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = $urandom;
  endtask

  // Grid sizes go out with random upper bits, which the block must ignore.
  task automatic setup_grid(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                            logic [COEF_W-1:0] cx, logic [COEF_W-1:0] cy);
    logic [COEF_W-1:0] junk;
    wait_drained();
    junk = $urandom;
    write_reg(CFG_GRID_WIDTH, {junk[COEF_W-1:DIM_W], w});
    junk = $urandom;
    write_reg(CFG_GRID_HEIGHT, {junk[COEF_W-1:DIM_W], h});
    write_reg(CFG_COEFF_X, cx);
    write_reg(CFG_COEFF_Y, cy);
    grids_used++;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return DIM_W'($urandom_range(2, 12));
    if (sel < 80) return DIM_W'($urandom_range(13, MAX_GRID_DIM));
    if (sel < 85) return DIM_MAX;
    if (sel < 92) return DIM_W'($urandom_range(0, 1));
    return DIM_W'($urandom_range(MAX_GRID_DIM + 1, 2047));
  endfunction

  function automatic logic [COEF_W-1:0] pick_coeff();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    if (sel < 40) return {16'($urandom_range(0, 255)), 16'h0};
    return $urandom;
  endfunction

  // Mostly rows inside the grid, biased toward its border; some noise.
  function automatic logic [ROW_W-1:0] pick_row();
    int unsigned w, h, sel, gi, gj;
    w = sb.used_width();
    h = sb.used_height();
    sel = $urandom_range(99);
    if (sel < 10) return ROW_W'($urandom);
    if (sel < 13) return '0;
    if (sel < 30) begin
      case ($urandom_range(2))
        0: gi = 0;
        1: gi = w - 1;
        default: gi = $urandom_range(w - 1);
      endcase
      case ($urandom_range(2))
        0: gj = 0;
        1: gj = h - 1;
        default: gj = $urandom_range(h - 1);
      endcase
      return ROW_W'(gj * w + gi);
    end
    return ROW_W'($urandom_range(w * h - 1));
  endfunction

  initial begin
    logic [ROW_W-1:0] row;
    int unsigned      phase, pct, n;
    int unsigned      idle_pct[4] = '{0, 84, 0, 23};

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: 2 by 2 grid, every row a corner, then one past the end
    for (int r = 0; r <= 4; r++) send_row(ROW_W'(r));

    // 5 by 4 grid: corners, edges, interior, beyond the grid
    setup_grid(11'd5, 11'd4, 32'h0003_0000, 32'h0001_2345);
    send_row(20'd0);  send_row(20'd4);  send_row(20'd15); send_row(20'd19);
    send_row(20'd2);  send_row(20'd5);  send_row(20'd9);  send_row(20'd17);
    send_row(20'd6);  send_row(20'd12); send_row(20'd20); send_row(20'hFFFFF);

    // out-of-range sizes clamp to 1024 by 2; zero coefficients
    setup_grid(11'd2047, 11'd0, 32'h0, 32'h0);
    send_row(20'd1023); send_row(20'd1536); send_row(20'd2048);

    // largest grid and coefficients
    setup_grid(DIM_MAX, DIM_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_row(20'd0); send_row(20'hFFFFF); send_row(20'hAAAAA); send_row(20'h55555);

    phase = 0;
    while (sb.rows_taken < 320) begin
      setup_grid(pick_dim(), pick_dim(), pick_coeff(), pick_coeff());
      pct = idle_pct[phase % 4];
      for (n = 0; n < 40; n++) begin
        // let everything drain once mid-phase before carrying on
        if (n == 20) wait_drained();
        row = pick_row();
        send_row(row);
        hold_off(pct);
      end
      phase++;
    end

    wait_drained();
    $display("rows requested: %0d (%0d outside the grid), entries checked: %0d",
             sb.rows_taken, sb.rows_outside, sb.entries_checked);
    $display("grid setups: %0d, mismatches: %0d", grids_used, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS poisson_stencil_row_generator_top");
    end else begin
      $display("FAIL poisson_stencil_row_generator_top");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("FAIL poisson_stencil_row_generator_top");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/psrg_pkg.sv
hw/rtl/psrg_div_stage.sv
hw/rtl/psrg_decode.sv
hw/rtl/psrg_emit.sv
hw/rtl/poisson_stencil_row_generator_top.sv
hw/rtl/psrg_checker.sv
tb/poisson_stencil_row_generator_top_tb.sv
